[design/rsa_pkg.sv]
// Shared types, constants and helpers for the residual statistics accumulator.
`timescale 1ns / 1ps
package rsa_pkg;
    localparam int MAX_SAMPLES = 4096;
    localparam int SAMPLE_BITS = 24;
    localparam int CNT_W  = 13;
    localparam int RES_W  = 25;
    localparam int SUM_W  = 37;
    localparam int SQ_W   = 62;
    localparam int DIV_W  = 64;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FEW   = 2'd1;
    localparam logic [1:0] STATUS_LIMIT = 2'd2;

    // Start and done handshake of the shared divider.
    typedef struct packed {
        logic start;
        logic [DIV_W-1:0] dividend;
        logic [DIV_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic done;
        logic [DIV_W-1:0] quotient;
    } div_rsp_t;

    // Sign-extend the low SAMPLE_BITS bits of a sample to 24 bits.
    function automatic logic signed [23:0] sext_sample(input logic [23:0] v);
        logic [23:0] m;
        m = v & ((24'd1 << SAMPLE_BITS) - 24'd1);
        if (m[SAMPLE_BITS-1]) begin
            m = m | ~((24'd1 << SAMPLE_BITS) - 24'd1);
        end
        return signed'(m);
    endfunction
endpackage

[design/rsa_divider.sv]
// Restoring radix-2 divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module rsa_divider (
    input  logic              aclk,
    input  logic              aresetn,
    input  rsa_pkg::div_req_t req,
    output rsa_pkg::div_rsp_t rsp
);
    import rsa_pkg::*;

    logic [DIV_W-1:0] quo_reg, quo_next;
    logic [DIV_W:0]   rem_reg, rem_next;
    logic [DIV_W-1:0] dvs_reg, dvs_next;
    logic [6:0]       cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DIV_W:0]   shifted;
    logic [DIV_W:0]   diff;

    // One shift-subtract step per cycle.
    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        shifted   = {rem_reg[DIV_W-1:0], quo_reg[DIV_W-1]};
        diff      = shifted - {1'b0, dvs_reg};
        if (req.start) begin
            quo_next  = req.dividend;
            rem_next  = '0;
            dvs_next  = req.divisor;
            cnt_next  = 7'(DIV_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!diff[DIV_W]) begin
                rem_next = diff;
                quo_next = {quo_reg[DIV_W-2:0], 1'b1};
            end else begin
                rem_next = shifted;
                quo_next = {quo_reg[DIV_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        cnt_reg <= cnt_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;
endmodule

[design/rsa_sqrt.sv]
// Bit-pair integer square root, one result bit per cycle.
`timescale 1ns / 1ps
module rsa_sqrt (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] radicand,
    output logic        done,
    output logic [31:0] root
);
    import rsa_pkg::*;

    logic [63:0] x_reg, x_next;
    logic [31:0] r_reg, r_next;
    logic [33:0] rem_reg, rem_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [33:0] trial;
    logic [33:0] cand;

    // Bring down two radicand bits and try one new root bit.
    always_comb begin
        x_next    = x_reg;
        r_next    = r_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        cand      = {rem_reg[31:0], x_reg[63:62]};
        trial     = {r_reg, 2'b01};
        if (start) begin
            x_next    = radicand;
            r_next    = '0;
            rem_next  = '0;
            cnt_next  = 6'd32;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            x_next = {x_reg[61:0], 2'b00};
            if (cand >= trial) begin
                rem_next = cand - trial;
                r_next   = {r_reg[30:0], 1'b1};
            end else begin
                rem_next = cand;
                r_next   = {r_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        x_reg   <= x_next;
        r_reg   <= r_next;
        rem_reg <= rem_next;
        cnt_reg <= cnt_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign done = done_reg;
    assign root = r_reg;
endmodule

[design/residual_statistics_accumulator_unit.sv]
// Top level: pair accumulation and the end-of-set statistics sequencer.
//
// After a pair beat without tlast is taken, the block is ready again on the next
// cycle. A beat with tlast starts the result sequence: up to four divisions
// (mean, mean absolute, mean square, then rms over the measured span, which
// is skipped when the span is zero) and one square root run one after another
// on a shared 64-step restoring divider and a 32-step root unit. With fewer
// than two pairs m_tvalid rises on the next cycle. Input tready is low while
// the sequence runs or a result waits to be taken. No clearing pass is needed.
`timescale 1ns / 1ps
module residual_statistics_accumulator_unit (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // tdata: predicted[23:0], measured[47:24]
    input  logic [47:0]  s_tdata,
    // tuser: predicted_missing[0], measured_missing[1]
    input  logic [1:0]   s_tuser,
    input  logic         s_tlast,
    output logic         m_tvalid,
    input  logic         m_tready,
    // tdata: status[1:0], pair_count[14:2], max_over[39:15], max_under[64:40],
    // mean_residual[89:65], mean_abs_residual[113:90], rms_residual[137:114],
    // normalized_rms[169:138]
    output logic [175:0] m_tdata
);
    import rsa_pkg::*;

    localparam logic [2:0] ST_ACC   = 3'd0;
    localparam logic [2:0] ST_MEAN  = 3'd1;
    localparam logic [2:0] ST_ABS   = 3'd2;
    localparam logic [2:0] ST_MSQ   = 3'd3;
    localparam logic [2:0] ST_ROOT  = 3'd4;
    localparam logic [2:0] ST_NORM  = 3'd5;
    localparam logic [2:0] ST_OUT   = 3'd6;

    logic [2:0] state_reg, state_next;
    logic       wait_reg, wait_next;

    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic signed [RES_W-1:0] rmax_reg, rmax_next, rmin_reg, rmin_next;
    logic signed [23:0]      mmax_reg, mmax_next, mmin_reg, mmin_next;
    logic signed [SUM_W-1:0] rsum_reg, rsum_next;
    logic [SUM_W-1:0]        asum_reg, asum_next;
    logic [SQ_W-1:0]         sq_reg, sq_next;
    logic                    lim_reg, lim_next;

    logic [1:0]        status_reg, status_next;
    logic [CNT_W-1:0]  pc_reg, pc_next;
    logic [RES_W-1:0]  over_reg, over_next, under_reg, under_next, mean_reg, mean_next;
    logic [23:0]       mabs_reg, mabs_next, rms_reg, rms_next;
    logic [31:0]       norm_reg, norm_next;
    logic              neg_reg, neg_next;
    logic [24:0]       span_reg, span_next;

    div_req_t    dreq;
    div_rsp_t    drsp;
    logic        sq_start, sq_done;
    logic [31:0] sq_root;

    logic signed [23:0]      p_s, m_s;
    logic signed [RES_W-1:0] r_s;
    logic [RES_W-2:0]        a_s;
    logic [47:0]             sq_term;
    logic                    take;
    logic [SUM_W-1:0]        rsum_abs;
    logic [DIV_W-1:0]        qmag;

    rsa_divider u_div (.aclk(aclk), .aresetn(aresetn), .req(dreq), .rsp(drsp));
    rsa_sqrt u_sqrt (
        .aclk(aclk), .aresetn(aresetn), .start(sq_start),
        .radicand(drsp.quotient), .done(sq_done), .root(sq_root)
    );

    assign s_tready = (state_reg == ST_ACC);
    assign m_tvalid = (state_reg == ST_OUT);
    assign m_tdata  = {6'd0, norm_reg, rms_reg, mabs_reg, mean_reg, under_reg,
                       over_reg, pc_reg, status_reg};

    assign p_s      = sext_sample(s_tdata[23:0]);
    assign m_s      = sext_sample(s_tdata[47:24]);
    assign r_s      = RES_W'(p_s) - RES_W'(m_s);
    assign a_s      = r_s[RES_W-1] ? 24'(-r_s) : r_s[RES_W-2:0];
    assign sq_term  = a_s * a_s;
    assign take     = s_tvalid && s_tready;
    assign rsum_abs = rsum_reg[SUM_W-1] ? SUM_W'(-rsum_reg) : SUM_W'(rsum_reg);
    assign qmag     = drsp.quotient;

    // Accumulation and the result sequencer.
    always_comb begin
        state_next = state_reg; wait_next = 1'b0;
        cnt_next = cnt_reg; rmax_next = rmax_reg; rmin_next = rmin_reg;
        mmax_next = mmax_reg; mmin_next = mmin_reg; rsum_next = rsum_reg;
        asum_next = asum_reg; sq_next = sq_reg; lim_next = lim_reg;
        status_next = status_reg; pc_next = pc_reg; over_next = over_reg;
        under_next = under_reg; mean_next = mean_reg; mabs_next = mabs_reg;
        rms_next = rms_reg; norm_next = norm_reg; neg_next = neg_reg;
        span_next = span_reg;
        dreq = '0; sq_start = 1'b0;
        unique case (state_reg)
            ST_ACC: begin
                if (take) begin
                    if (!s_tuser[0] && !s_tuser[1]) begin
                        if (cnt_reg >= CNT_W'(MAX_SAMPLES)) begin
                            lim_next = 1'b1;
                        end else begin
                            if (cnt_reg == '0) begin
                                rmax_next = r_s; rmin_next = r_s;
                                mmax_next = m_s; mmin_next = m_s;
                            end else begin
                                if (r_s > rmax_reg) rmax_next = r_s;
                                if (r_s < rmin_reg) rmin_next = r_s;
                                if (m_s > mmax_reg) mmax_next = m_s;
                                if (m_s < mmin_reg) mmin_next = m_s;
                            end
                            cnt_next  = cnt_reg + CNT_W'(1);
                            rsum_next = rsum_reg + SUM_W'(r_s);
                            asum_next = asum_reg + SUM_W'(a_s);
                            sq_next   = sq_reg + SQ_W'(sq_term);
                        end
                    end
                    if (s_tlast) begin
                        pc_next = cnt_next;
                        over_next = '0; under_next = '0; mean_next = '0;
                        mabs_next = '0; rms_next = '0; norm_next = '0;
                        if (cnt_next < CNT_W'(2)) begin
                            status_next = STATUS_FEW;
                            state_next  = ST_OUT;
                        end else begin
                            status_next = lim_next ? STATUS_LIMIT : STATUS_OK;
                            over_next   = rmax_next;
                            under_next  = RES_W'(-rmin_next);
                            span_next   = 25'(mmax_next) - 25'(mmin_next);
                            state_next  = ST_MEAN;
                            wait_next   = 1'b1;
                        end
                    end
                end
            end
            ST_MEAN: begin
                if (wait_reg) begin
                    dreq.start = 1'b1; dreq.dividend = DIV_W'(rsum_abs);
                    dreq.divisor = DIV_W'(cnt_reg);
                    neg_next = rsum_reg[SUM_W-1];
                end else if (drsp.done) begin
                    mean_next = neg_reg ? RES_W'(-qmag) : RES_W'(qmag);
                    dreq.start = 1'b1; dreq.dividend = DIV_W'(asum_reg);
                    dreq.divisor = DIV_W'(cnt_reg);
                    state_next = ST_ABS;
                end
            end
            ST_ABS: begin
                if (drsp.done) begin
                    mabs_next = qmag[23:0];
                    dreq.start = 1'b1; dreq.dividend = DIV_W'(sq_reg);
                    dreq.divisor = DIV_W'(cnt_reg);
                    state_next = ST_MSQ;
                end
            end
            ST_MSQ: begin
                if (drsp.done) begin
                    sq_start = 1'b1;
                    state_next = ST_ROOT;
                end
            end
            ST_ROOT: begin
                if (sq_done) begin
                    rms_next = sq_root[23:0];
                    if (span_reg == '0) begin
                        state_next = ST_OUT;
                    end else begin
                        dreq.start = 1'b1;
                        dreq.dividend = DIV_W'(sq_root[23:0]) * DIV_W'(25600);
                        dreq.divisor = DIV_W'(span_reg);
                        state_next = ST_NORM;
                    end
                end
            end
            ST_NORM: begin
                if (drsp.done) begin
                    norm_next = (qmag[DIV_W-1:32] != '0) ? 32'hFFFF_FFFF : qmag[31:0];
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (m_tready) begin
                    state_next = ST_ACC;
                end
            end
            default: state_next = ST_ACC;
        endcase
        // Clear the accumulators once the set is closed.
        if (state_next == ST_OUT && state_reg != ST_OUT) begin
            cnt_next = '0; rmax_next = '0; rmin_next = '0; mmax_next = '0;
            mmin_next = '0; rsum_next = '0; asum_next = '0; sq_next = '0;
            lim_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        status_reg <= status_next; pc_reg <= pc_next; over_reg <= over_next;
        under_reg <= under_next; mean_reg <= mean_next; mabs_reg <= mabs_next;
        rms_reg <= rms_next; norm_reg <= norm_next; neg_reg <= neg_next;
        span_reg <= span_next;
        if (!aresetn) begin
            state_reg <= ST_ACC; wait_reg <= 1'b0;
            cnt_reg <= '0; rmax_reg <= '0; rmin_reg <= '0; mmax_reg <= '0;
            mmin_reg <= '0; rsum_reg <= '0; asum_reg <= '0; sq_reg <= '0;
            lim_reg <= 1'b0;
        end else begin
            state_reg <= state_next; wait_reg <= wait_next;
            cnt_reg <= cnt_next; rmax_reg <= rmax_next; rmin_reg <= rmin_next;
            mmax_reg <= mmax_next; mmin_reg <= mmin_next; rsum_reg <= rsum_next;
            asum_reg <= asum_next; sq_reg <= sq_next; lim_reg <= lim_next;
        end
    end
endmodule

[design/rsa_checker.sv]
// Port-level checks for the accumulator, bound to the top level.
`timescale 1ns / 1ps
module rsa_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         s_tlast,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [175:0] m_tdata
);
    // The block never takes a beat while a result is shown.
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready) else $error("input ready while result pending");

    // A result holds until taken.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped or changed");

    // Status is never the unused code.
    a_stat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[1:0] != 2'd3) else $error("bad status");

    // A non-last beat never leaves the block busy.
    a_nolast: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && !s_tlast |=> s_tready) else $error("stalled");
endmodule

bind residual_statistics_accumulator_unit rsa_checker u_rsa_checker (.*);

[bench/residual_statistics_accumulator_unit_test.sv]
// Self-checking bench for the residual statistics accumulator: directed and random pair sets against a predictor.
`timescale 1ns / 1ps
module residual_statistics_accumulator_unit_test;
    import rsa_pkg::*;

    // Highest field first, so status lands in the lowest bits.
    typedef struct packed {
        logic [31:0] normalized_rms;
        logic [23:0] rms_residual;
        logic [23:0] mean_abs_residual;
        logic [24:0] mean_residual;
        logic [24:0] max_under;
        logic [24:0] max_over;
        logic [12:0] pair_count;
        logic [1:0]  status;
    } stats_t;

    typedef struct packed {
        logic [23:0] predicted;
        logic [23:0] measured;
        logic        pred_miss;
        logic        meas_miss;
        logic        last;
    } pair_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [47:0]  s_tdata = '0;
    logic [1:0]   s_tuser = '0;
    logic         s_tlast = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [175:0] m_tdata;

    residual_statistics_accumulator_unit dut (.*);

    always #5 aclk = ~aclk;

    pair_t  pending_pairs[$];
    stats_t expected_stats[$];
    int     error_count = 0;
    int     cycle_count = 0;
    bit     stim_done = 1'b0;
    bit     calm = 1'b0;
    int     hold_cycles = 0;

    // Predictor state for the current data set.
    int unsigned    acc_count;
    longint         acc_rmax, acc_rmin, acc_mmax, acc_mmin, acc_sum;
    longint unsigned acc_abs, acc_sq;
    bit             acc_limit;

    function automatic void clear_accumulators();
        acc_count = 0; acc_rmax = 0; acc_rmin = 0; acc_mmax = 0; acc_mmin = 0;
        acc_sum = 0; acc_abs = 0; acc_sq = 0; acc_limit = 0;
    endfunction

    function automatic longint unsigned floor_root(longint unsigned x);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > x) bitv >>= 2;
        while (bitv != 0) begin
            if (x >= res + bitv) begin
                x -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    // Take one pair into the predictor; queue the statistics on last.
    task automatic absorb_pair(pair_t p);
        longint pv, mv, r;
        longint unsigned a, rms, span, norm;
        longint n;
        stats_t s;
        if (!p.pred_miss && !p.meas_miss) begin
            if (acc_count >= MAX_SAMPLES) begin
                acc_limit = 1;
            end else begin
                pv = longint'($signed(p.predicted));
                mv = longint'($signed(p.measured));
                r = pv - mv;
                a = (r < 0) ? -r : r;
                if (acc_count == 0) begin
                    acc_rmax = r; acc_rmin = r; acc_mmax = mv; acc_mmin = mv;
                end else begin
                    if (r > acc_rmax) acc_rmax = r;
                    if (r < acc_rmin) acc_rmin = r;
                    if (mv > acc_mmax) acc_mmax = mv;
                    if (mv < acc_mmin) acc_mmin = mv;
                end
                acc_count++;
                acc_sum += r;
                acc_abs += a;
                acc_sq += a * a;
            end
        end
        if (p.last) begin
            s = '0;
            s.pair_count = acc_count[12:0];
            if (acc_count < 2) begin
                s.status = STATUS_FEW;
            end else begin
                n = acc_count;
                rms = floor_root(acc_sq / acc_count);
                span = acc_mmax - acc_mmin;
                norm = 0;
                if (span != 0) begin
                    norm = (rms * 25600) / span;
                    if (norm > 64'hFFFF_FFFF) norm = 64'hFFFF_FFFF;
                end
                s.status = acc_limit ? STATUS_LIMIT : STATUS_OK;
                s.max_over = acc_rmax[24:0];
                s.max_under = 25'(-acc_rmin);
                s.mean_residual = 25'(acc_sum / n);
                s.mean_abs_residual = 24'(acc_abs / acc_count);
                s.rms_residual = rms[23:0];
                s.normalized_rms = norm[31:0];
            end
            expected_stats.push_back(s);
            clear_accumulators();
        end
    endtask

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0h expected %0h", what, got, want);
        error_count++;
    endtask

    function automatic logic [23:0] pick_sample(int mode);
        case (mode)
            0: return 24'h7FFFFF;
            1: return 24'h800000;
            2: return 24'($urandom_range(0, 15));
            default: return 24'($urandom());
        endcase
    endfunction

    task automatic add_pair(logic [23:0] p, logic [23:0] m, bit pm, bit mm, bit l);
        pair_t x;
        x.predicted = p; x.measured = m; x.pred_miss = pm; x.meas_miss = mm;
        x.last = l;
        pending_pairs.push_back(x);
    endtask

    // Stimulus: directed sets, then random sets with content from all ranges.
    initial begin
        int len, set_mode;
        clear_accumulators();
        // Two single-pair sets, then a set of only missing pairs.
        add_pair(24'h000100, 24'h000000, 0, 0, 1);
        add_pair(24'h0, 24'h0, 0, 0, 1);
        add_pair(24'h1, 24'h2, 1, 0, 0);
        add_pair(24'h1, 24'h2, 0, 1, 0);
        add_pair(24'h1, 24'h2, 1, 1, 1);
        // Extremes, both signs of residual.
        add_pair(24'h7FFFFF, 24'h800000, 0, 0, 0);
        add_pair(24'h800000, 24'h7FFFFF, 0, 0, 0);
        add_pair(24'h000000, 24'h000000, 0, 0, 1);
        // Zero span and zero residuals.
        add_pair(24'h000500, 24'h000500, 0, 0, 0);
        add_pair(24'h000500, 24'h000500, 0, 0, 1);
        // Zero span, nonzero residuals.
        add_pair(24'h000900, 24'h000100, 0, 0, 0);
        add_pair(24'hFFF000, 24'h000100, 0, 0, 1);
        // Tiny span, large rms: saturation.
        add_pair(24'h7FFFFF, 24'h000000, 0, 0, 0);
        add_pair(24'h800000, 24'h000001, 0, 0, 1);
        // Last beat carries a skipped pair.
        add_pair(24'h000010, 24'h000003, 0, 0, 0);
        add_pair(24'h000020, 24'hFFFFF0, 0, 0, 0);
        add_pair(24'h123456, 24'h000000, 1, 0, 1);
        // Random sets, mostly short.
        while (pending_pairs.size() < 650) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
            set_mode = $urandom_range(0, 3);
            for (int i = 0; i < len; i++)
                add_pair(pick_sample($urandom_range(0, 5) == 0 ? $urandom_range(0, 2) : set_mode),
                         pick_sample($urandom_range(0, 5) == 0 ? $urandom_range(0, 2) : set_mode),
                         $urandom_range(0, 9) == 0, $urandom_range(0, 9) == 0,
                         i == len - 1);
        end
        stim_done = 1'b1;
    end

    // Reset and end of run.
    initial begin
        int settle;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        wait (stim_done && pending_pairs.size() == 0 && !s_tvalid);
        while (expected_stats.size() != 0) @(posedge aclk);
        settle = 0;
        while (settle < 300) begin
            @(posedge aclk);
            settle++;
        end
        if (error_count == 0 && expected_stats.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // Watchdog.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 2000000) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Driver: offers pending pairs with random gaps; gaps end near the finish.
    int send_gap = 0;
    always @(posedge aclk) begin
        if (aresetn) begin
            calm <= pending_pairs.size() < 150;
            if (s_tvalid && s_tready)
                absorb_pair({s_tdata[23:0], s_tdata[47:24], s_tuser[0], s_tuser[1], s_tlast});
            if (!s_tvalid || s_tready) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    s_tvalid <= 1'b0;
                end else if (pending_pairs.size() != 0) begin
                    pair_t x;
                    x = pending_pairs.pop_front();
                    s_tdata <= {x.measured, x.predicted};
                    s_tuser <= {x.meas_miss, x.pred_miss};
                    s_tlast <= x.last;
                    s_tvalid <= 1'b1;
                    if (!calm && $urandom_range(0, 7) == 0) send_gap <= $urandom_range(1, 6);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: random stalls, one long hold-off, field by field compare.
    int stall_left = 0;
    always @(posedge aclk) begin
        stats_t got, want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got = m_tdata[169:0];
                if (expected_stats.size() == 0) begin
                    report_mismatch("unexpected beat", got.status, 0);
                end else begin
                    want = expected_stats.pop_front();
                    if (got.status !== want.status)
                        report_mismatch("status", got.status, want.status);
                    if (got.pair_count !== want.pair_count)
                        report_mismatch("pair_count", got.pair_count, want.pair_count);
                    if (got.max_over !== want.max_over)
                        report_mismatch("max_over", got.max_over, want.max_over);
                    if (got.max_under !== want.max_under)
                        report_mismatch("max_under", got.max_under, want.max_under);
                    if (got.mean_residual !== want.mean_residual)
                        report_mismatch("mean_residual", got.mean_residual, want.mean_residual);
                    if (got.mean_abs_residual !== want.mean_abs_residual)
                        report_mismatch("mean_abs_residual", got.mean_abs_residual,
                                        want.mean_abs_residual);
                    if (got.rms_residual !== want.rms_residual)
                        report_mismatch("rms_residual", got.rms_residual, want.rms_residual);
                    if (got.normalized_rms !== want.normalized_rms)
                        report_mismatch("normalized_rms", got.normalized_rms,
                                        want.normalized_rms);
                end
            end
            // One long hold-off early in the run while pairs keep coming.
            if (hold_cycles == 0 && cycle_count > 3000) begin
                hold_cycles <= 1;
                stall_left <= 2000;
                m_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                m_tready <= 1'b0;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                stall_left <= $urandom_range(0, 5);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end
endmodule

[sim.f]
design/rsa_pkg.sv
design/rsa_divider.sv
design/rsa_sqrt.sv
design/residual_statistics_accumulator_unit.sv
design/rsa_checker.sv
bench/residual_statistics_accumulator_unit_test.sv
